>>> src/odec_pkg.sv
// Shared types and constants for the object identifier node decoder.
package odec_pkg;

    // Decoded result beat
    typedef struct packed {
        logic [15:0] node_value;
        logic [7:0]  node_index;
        logic        has_node;
        logic        end_of_oid;
        logic [7:0]  node_count;
        logic        last_in_run;
    } result_t;

    // Up to two results produced by one accepted byte
    typedef struct packed {
        logic [1:0] num;
        result_t    res0;
        result_t    res1;
    } push_t;

    localparam logic [7:0] MAX_NODES_RESET = 8'd16;
    localparam logic [7:0] ARC_RADIX       = 8'd40;
    localparam logic [7:0] PAYLOAD_MASK    = 8'h7F;
    localparam logic [7:0] CONT_MASK       = 8'h80;
    localparam int         QUEUE_DEPTH     = 4;
    localparam int         QPTR_BITS       = 2;
    localparam int         QCNT_BITS       = 3;

    // First byte quotient by 40: multiply by 205 and shift 13, exact for 8-bit values
    function automatic logic [7:0] div_radix(input logic [7:0] b);
        logic [15:0] prod;
        prod = 16'(b) * 16'd205;
        return {5'b0, prod[15:13]};
    endfunction

    // Remainder by 40 from the quotient
    function automatic logic [7:0] mod_radix(input logic [7:0] b);
        logic [7:0] quo;
        logic [15:0] back;
        quo  = div_radix(b);
        back = 16'(quo) * 16'(ARC_RADIX);
        return b - back[7:0];
    endfunction

endpackage

>>> src/odec_if.sv
// Handshake channels for encoded bytes and decoded node results.
interface odec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input last_byte, output ready);
endinterface

interface odec_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] node_value;
    logic [7:0]  node_index;
    logic        has_node;
    logic        end_of_oid;
    logic [7:0]  node_count;
    logic        last_in_run;

    modport source (output valid, output node_value, output node_index,
                    output has_node, output end_of_oid, output node_count,
                    output last_in_run, input ready);
    modport sink (input valid, input node_value, input node_index,
                  input has_node, input end_of_oid, input node_count,
                  input last_in_run, output ready);
endinterface

>>> src/odec_front.sv
// Front end: accepts content bytes, tracks the partial node and classifies results.
module odec_front
    import odec_pkg::*;
#(
    parameter int NODE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    odec_in_if.sink      bytes,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         space_ok,
    output logic         push_valid,
    output push_t        push
);

    logic [NODE_BITS-1:0] acc_reg, acc_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic [7:0]           max_nodes_reg;
    logic [NODE_BITS-1:0] acc_shift;
    logic [31:0]          acc_wide;
    logic [7:0]           byte_v;
    logic                 accept;

    assign bytes.ready = space_ok;
    assign accept      = bytes.valid && space_ok;
    assign push_valid  = accept;
    assign byte_v      = bytes.data_byte;

    // Shift in seven payload bits, wrapping at the accumulator width
    assign acc_shift = {acc_reg[NODE_BITS-8:0], 7'b0}
                     + NODE_BITS'(byte_v & PAYLOAD_MASK);
    assign acc_wide  = 32'(acc_shift);

    // Classify the byte and form its results
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        push     = '0;
        if (bytes.first_byte)
        begin
            acc_next = '0;
            cnt_next = '0;
            if (max_nodes_reg != 8'd0)
            begin
                push.res0 = '{node_value: 16'(div_radix(byte_v)), node_index: 8'd0,
                              has_node: 1'b1, end_of_oid: 1'b0, node_count: 8'd1,
                              last_in_run: 1'b0};
                push.num  = 2'd1;
                cnt_next  = 8'd1;
            end
            if (max_nodes_reg > 8'd1)
            begin
                push.res1 = '{node_value: 16'(mod_radix(byte_v)), node_index: 8'd1,
                              has_node: 1'b1, end_of_oid: 1'b0, node_count: 8'd2,
                              last_in_run: 1'b0};
                push.num  = 2'd2;
                cnt_next  = 8'd2;
            end
        end
        else if (cnt_reg < max_nodes_reg)
        begin
            if (((byte_v & CONT_MASK) == 8'd0) || bytes.last_byte)
            begin
                push.res0 = '{node_value: acc_wide[15:0], node_index: cnt_reg,
                              has_node: 1'b1, end_of_oid: 1'b0,
                              node_count: cnt_reg + 8'd1, last_in_run: 1'b0};
                push.num  = 2'd1;
                acc_next  = '0;
                cnt_next  = cnt_reg + 8'd1;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end

        // Close the identifier, adding an end marker when nothing else came out
        if (bytes.last_byte)
        begin
            if (push.num == 2'd0)
            begin
                push.res0 = '{node_value: 16'd0, node_index: 8'd0, has_node: 1'b0,
                              end_of_oid: 1'b0, node_count: cnt_next,
                              last_in_run: 1'b0};
                push.num  = 2'd1;
            end
            if (push.num == 2'd2)
                push.res1.end_of_oid = 1'b1;
            else
                push.res0.end_of_oid = 1'b1;
            acc_next = '0;
            cnt_next = '0;
        end

        // Mark the final result of this byte
        if (push.num == 2'd2)
            push.res1.last_in_run = 1'b1;
        else if (push.num == 2'd1)
            push.res0.last_in_run = 1'b1;
    end

    // Advance decoder state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the node limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_nodes_reg <= MAX_NODES_RESET;
        else if (cfg_wr_en)
            max_nodes_reg <= cfg_wr_data;
    end

endmodule

>>> src/odec_back.sv
// Back end: result queue; up to two in a cycle with room, one out a cycle if ready.
module odec_back
    import odec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  push_t        push,
    output logic         space_ok,
    odec_out_if.source   nodes
);

    result_t              mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [QPTR_BITS-1:0] wr_ptr_plus;
    logic [QCNT_BITS-1:0] push_num;
    logic                 pop;
    result_t              head;

    assign wr_ptr_plus = wr_ptr_reg + QPTR_BITS'(1);
    assign push_num    = push_valid ? QCNT_BITS'(push.num) : '0;
    assign pop         = nodes.valid && nodes.ready;
    assign space_ok    = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);

    // Present the head entry
    assign head              = mem[rd_ptr_reg];
    assign nodes.valid       = count_reg != '0;
    assign nodes.node_value  = head.node_value;
    assign nodes.node_index  = head.node_index;
    assign nodes.has_node    = head.has_node;
    assign nodes.end_of_oid  = head.end_of_oid;
    assign nodes.node_count  = head.node_count;
    assign nodes.last_in_run = head.last_in_run;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_num[QPTR_BITS-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + push_num - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write one or two results
    always_ff @(posedge clk)
    begin
        if (push_valid && push.num != 2'd0)
            mem[wr_ptr_reg] <= push.res0;
        if (push_valid && push.num == 2'd2)
            mem[wr_ptr_plus] <= push.res1;
    end

endmodule

>>> src/oid_node_decoder.sv
// Each result is registered in the result queue when its byte is accepted.
// Throughput: one byte per cycle while the queue has room; a first byte yields up to two results, sent one at a time.
// A four-entry result queue decouples input and output; input stalls when fewer
// than two entries are free.
// Reset clears the partial node, the node count and the queue; max_nodes returns to 16.
module oid_node_decoder
    import odec_pkg::*;
#(
    parameter int NODE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    odec_in_if.sink      bytes,
    odec_out_if.source   nodes,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data
);

    logic  space_ok;
    logic  push_valid;
    push_t push;

    // Decode bytes into results
    odec_front #(
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .space_ok    (space_ok),
        .push_valid  (push_valid),
        .push        (push)
    );

    // Queue and send results
    odec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push       (push),
        .space_ok   (space_ok),
        .nodes      (nodes)
    );

endmodule

>>> src/odec_checker.sv
// Port-level assertions for the node decoder, bound to the top level.
module odec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] node_value,
    input logic [7:0]  node_index,
    input logic        has_node,
    input logic        end_of_oid,
    input logic [7:0]  node_count,
    input logic        last_in_run
);

    // A stalled result beat stays valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // End of identifier always closes the run of its byte
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_oid |-> last_in_run)
        else $error("end_of_oid without last_in_run");

    // An end marker carries no node
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_node |-> end_of_oid && last_in_run
                                   && node_value == 16'd0 && node_index == 8'd0)
        else $error("malformed end marker");

    // A node's count is one past its index
    a_count_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_node |-> node_count == node_index + 8'd1)
        else $error("node_count does not follow node_index");

endmodule

bind oid_node_decoder odec_checker u_odec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (nodes.valid),
    .out_ready   (nodes.ready),
    .node_value  (nodes.node_value),
    .node_index  (nodes.node_index),
    .has_node    (nodes.has_node),
    .end_of_oid  (nodes.end_of_oid),
    .node_count  (nodes.node_count),
    .last_in_run (nodes.last_in_run)
);

>>> bench/tb_oid_node_decoder.sv
// Testbench for the object identifier node decoder: predicted node results checked per beat.
module tb_oid_node_decoder
    import odec_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    odec_in_if  byte_ch ();
    odec_out_if node_ch ();

    oid_node_decoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (byte_ch),
        .nodes       (node_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Decoder state as predicted by the bench
    logic [7:0]  node_limit;
    logic [15:0] part_node;
    logic [7:0]  oid_nodes;
    result_t     pending_nodes[$];

    int mismatches;
    int bytes_sent;
    int results_seen;
    int oid_ends;
    int cfg_writes;
    int hold_len;
    int stall_left;
    bit steady;

    // Toggle the clock
    always #5 clk = ~clk;

    // Pick an idle length: mostly none or short, now and then long
    function automatic int gap_length();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Produce one node result and advance the node count
    function automatic result_t make_node(input logic [15:0] value);
        result_t r;
        r = '0;
        r.node_value = value;
        r.node_index = oid_nodes;
        oid_nodes    = oid_nodes + 8'd1;
        r.has_node   = 1'b1;
        r.node_count = oid_nodes;
        return r;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void decode_byte(input logic [7:0] b, input logic first,
                                        input logic last);
        result_t run[2];
        int      n;
        n = 0;
        if (first)
        begin
            part_node = '0;
            oid_nodes = '0;
            if (oid_nodes < node_limit)
            begin
                run[n] = make_node({8'd0, b / ARC_RADIX});
                n = n + 1;
            end
            if (oid_nodes < node_limit)
            begin
                run[n] = make_node({8'd0, b % ARC_RADIX});
                n = n + 1;
            end
        end
        else if (oid_nodes < node_limit)
        begin
            part_node = (part_node << 7) | {8'd0, b & PAYLOAD_MASK};
            if ((b & CONT_MASK) == 8'd0 || last)
            begin
                run[n] = make_node(part_node);
                n = n + 1;
                part_node = '0;
            end
        end
        // Close the identifier, with a bare end marker if no node came out
        if (last)
        begin
            if (n == 0)
            begin
                run[0] = '0;
                run[0].node_count = oid_nodes;
                n = 1;
            end
            run[n - 1].end_of_oid = 1'b1;
            part_node = '0;
            oid_nodes = '0;
        end
        if (n > 0)
            run[n - 1].last_in_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_nodes.push_back(run[i]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && node_ch.valid && node_ch.ready)
        begin
            if (pending_nodes.size() == 0)
            begin
                $error("node_value: no result pending, got %0d", node_ch.node_value);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_nodes.pop_front();
                check_field("node_value", want.node_value, node_ch.node_value);
                check_field("node_index", want.node_index, node_ch.node_index);
                check_field("has_node", want.has_node, node_ch.has_node);
                check_field("end_of_oid", want.end_of_oid, node_ch.end_of_oid);
                check_field("node_count", want.node_count, node_ch.node_count);
                check_field("last_in_run", want.last_in_run, node_ch.last_in_run);
                results_seen = results_seen + 1;
                if (want.end_of_oid)
                    oid_ends = oid_ends + 1;
            end
        end
    end

    // Drive the result ready: long hold-off first, else random stalls
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_len = hold_len - 1;
            node_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
                stall_left = gap_length();
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                node_ch.ready <= 1'b0;
            end
            else
                node_ch.ready <= 1'b1;
        end
    end

    // Offer one byte beat and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.first_byte <= first;
        byte_ch.last_byte  <= last;
        do
            @(posedge clk);
        while (!(byte_ch.valid && byte_ch.ready));
        decode_byte(b, first, last);
        bytes_sent = bytes_sent + 1;
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_nodes.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_nodes(input logic [7:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        node_limit = value;
        cfg_writes = cfg_writes + 1;
    endtask

    // Build one identifier: mostly well formed, some noise and broken ones
    task automatic send_random_oid();
        logic [9:0] beats[$];
        logic [7:0] b;
        int         kind;
        int         later;
        int         len;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            return;
        end
        // Skip the first byte now and then
        if (kind != 1)
            beats.push_back({8'($urandom_range(0, 255)), 2'b10});
        later = $urandom_range(0, 5);
        for (int i = 0; i < later; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 2);
            for (int j = 0; j < len; j++)
            begin
                b = 8'($urandom_range(0, 127));
                if (j < len - 1)
                    b[7] = 1'b1;
                beats.push_back({b, 2'b00});
            end
        end
        if (beats.size() == 0)
            beats.push_back({8'($urandom_range(0, 255)), 2'b00});
        // Leave the final node unfinished
        if (kind == 2 && later > 0)
            beats[beats.size() - 1][9] = 1'b1;
        // Close the identifier, but now and then leave it open so the next one runs into it
        if (kind != 3)
            beats[beats.size() - 1][0] = 1'b1;
        foreach (beats[i])
            send_byte(beats[i][9:2], beats[i][1], beats[i][0]);
    endtask

    task automatic test_directed_oid();
        // 1.3.6.1.128.1 with a two-byte node
        send_byte(8'h2B, 1'b1, 1'b0);
        send_byte(8'h06, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // Identifier made of a single zero first byte
        send_byte(8'h00, 1'b1, 1'b1);
        // Largest first byte, then a node that wraps the accumulator
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
        // Last byte still has its continuation bit set
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'h85, 1'b0, 1'b1);
        // Identifiers with no first byte
        send_byte(8'h12, 1'b0, 1'b1);
        send_byte(8'h83, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_node_limit();
        // No nodes at all: end markers only
        write_max_nodes(8'd0);
        send_byte(8'h2B, 1'b1, 1'b0);
        send_byte(8'h05, 1'b0, 1'b1);
        send_byte(8'h9C, 1'b0, 1'b1);
        // One node: first byte gives only its quotient
        write_max_nodes(8'd1);
        send_byte(8'h2B, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h77, 1'b1, 1'b1);
        // Quota reached by a later node, remaining bytes ignored
        write_max_nodes(8'd3);
        send_byte(8'h50, 1'b1, 1'b0);
        send_byte(8'h81, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h88, 1'b0, 1'b0);
        send_byte(8'h08, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_long_oid();
        // Fill the largest quota, then one ignored last byte
        write_max_nodes(8'd255);
        send_byte(8'h2B, 1'b1, 1'b0);
        for (int i = 0; i < 253; i++)
            send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_random_oids();
        int start;
        int next_change;
        int pick;
        start       = bytes_sent;
        next_change = bytes_sent;
        while (bytes_sent < start + 100)
        begin
            // Move to a new quota every couple dozen bytes
            if (bytes_sent >= next_change)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_max_nodes(MAX_NODES_RESET);
                else if (pick == 1)
                    write_max_nodes(8'($urandom_range(0, 4)));
                else
                    write_max_nodes(8'($urandom_range(5, 255)));
                next_change = bytes_sent + 25;
            end
            steady = (((bytes_sent - start) / 20) % 4) == 3;
            send_random_oid();
        end
        steady = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        // Hold the receiver while bytes keep coming, so the input stalls
        write_max_nodes(MAX_NODES_RESET);
        steady   = 1'b1;
        hold_len = 80;
        for (int i = 0; i < 8; i++)
            send_random_oid();
        steady = 1'b0;
        drain();
    endtask

    // Reset, run the tests in turn, then report
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.first_byte = 1'b0;
        byte_ch.last_byte = 1'b0;
        node_ch.ready     = 1'b0;
        node_limit        = MAX_NODES_RESET;
        part_node         = '0;
        oid_nodes         = '0;
        mismatches        = 0;
        bytes_sent        = 0;
        results_seen      = 0;
        oid_ends          = 0;
        cfg_writes        = 0;
        hold_len          = 0;
        stall_left        = 0;
        steady            = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_oid();
        test_node_limit();
        test_long_oid();
        test_random_oids();
        test_backpressure();
        drain();

        $display("Sent %0d bytes; checked %0d node results and %0d identifier ends.",
                 bytes_sent, results_seen, oid_ends);
        $display("Wrote max_nodes %0d times, 0 and 255 among the values.", cfg_writes);
        if (mismatches == 0 && pending_nodes.size() == 0)
            $display("tb_oid_node_decoder OK");
        else
            $display("tb_oid_node_decoder NOT OK");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5000000;
        $display("tb_oid_node_decoder NOT OK");
        $finish;
    end

endmodule
